FILE: hw/rtl/ebrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebrs_pkg
// Shared types and constants for the execution buffer register scoreboard.
// ----------------------------------------------------------------------------
package ebrs_pkg;

  // Table geometry
  localparam int DEPTH       = 8;
  localparam int MAX_SOURCES = 4;
  localparam int SRC_FIELDS  = 4;
  localparam int SRC_LIMIT   = (MAX_SOURCES < SRC_FIELDS) ? MAX_SOURCES : SRC_FIELDS;

  // Field widths
  localparam int WARP_W = 16;
  localparam int REG_W  = 8;
  localparam int LAT_W  = 10;
  localparam int NSRC_W = 3;
  localparam int EXW_W  = 4;
  localparam int OCC_W  = 4;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = 8;

  // Operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CHECK = 2'd1,
    OP_ISSUE = 2'd2
  } op_e;

  // Control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  // Command broadcast to every cell
  typedef struct packed {
    logic                              en;
    logic [1:0]                        op;
    logic [WARP_W-1:0]                 warp;
    logic [REG_W-1:0]                  dest;
    logic [LAT_W-1:0]                  latency;
    logic [NSRC_W-1:0]                 nsrc;
    logic [SRC_FIELDS-1:0][REG_W-1:0]  src;
  } cmd_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] count;
  } link_t;

endpackage : ebrs_pkg
`default_nettype wire

FILE: hw/rtl/ebrs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebrs_cell
// One scoreboard entry. Ages on tick, matches sources on check, takes the
// issue grant when free, and extends the hit and live-count chain.
// ----------------------------------------------------------------------------
module ebrs_cell
  import ebrs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  grant_i,
  output logic       grant_o,
  input  wire link_t link_i,
  output link_t      link_o
);

  logic              valid_q, valid_d;
  logic [WARP_W-1:0] warp_q;
  logic [REG_W-1:0]  dest_q;
  logic [LAT_W-1:0]  rem_q;
  logic              take;
  logic              match;

  // Source compare against the stored destination
  always_comb begin
    match = 1'b0;
    for (int j = 0; j < SRC_FIELDS; j++) begin
      if ((NSRC_W'(j) < cmd_i.nsrc) && (dest_q == cmd_i.src[j])) begin
        match = 1'b1;
      end
    end
    match = match && valid_q && (warp_q == cmd_i.warp);
  end

  // Grant passes on only over occupied cells
  assign take    = grant_i && !valid_q;
  assign grant_o = grant_i && valid_q;

  // Chain to the neighbor
  always_comb begin
    link_o.hit   = link_i.hit || (match && (cmd_i.op == OP_CHECK));
    link_o.count = link_i.count + CNT_W'(valid_q);
  end

  // Valid next state
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.en) begin
      if ((cmd_i.op == OP_TICK) && valid_q && (rem_q <= LAT_W'(1))) begin
        valid_d = 1'b0;
      end else if ((cmd_i.op == OP_ISSUE) && take) begin
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload: written on issue, aged on tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if ((cmd_i.op == OP_ISSUE) && take) begin
        warp_q <= cmd_i.warp;
        dest_q <= cmd_i.dest;
        rem_q  <= cmd_i.latency;
      end else if ((cmd_i.op == OP_TICK) && valid_q && (rem_q > LAT_W'(1))) begin
        rem_q <= rem_q - LAT_W'(1);
      end
    end
  end

endmodule : ebrs_cell
`default_nettype wire

FILE: hw/rtl/exec_buffer_register_scoreboard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exec_buffer_register_scoreboard
// Scoreboard of in-flight compute instructions built as a row of entry cells.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  command   | start / busy         | op, warp_id, dst_reg, latency, num_src,
//            |                      | src_reg0..src_reg3
//  result    | done_o (one cycle)   | conflict_o, full_res_o, occupancy_o
//  config    | cfg_we_i             | cfg_wdata_i (exec_width)
//
// Items are taken only while idle: the cells update at the accepting edge,
// and the result shows in the following cycle, while busy is high. The live
// count comes from the ripple through the cell row. Reset clears every entry
// and sets exec_width to 8. The receiver cannot stall; no result is ever held back.
// ----------------------------------------------------------------------------
module exec_buffer_register_scoreboard
  import ebrs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op_i,
  input  wire logic [WARP_W-1:0] warp_id_i,
  input  wire logic [REG_W-1:0]  dst_reg_i,
  input  wire logic [LAT_W-1:0]  latency_i,
  input  wire logic [NSRC_W-1:0] num_src_i,
  input  wire logic [REG_W-1:0]  src_reg0_i,
  input  wire logic [REG_W-1:0]  src_reg1_i,
  input  wire logic [REG_W-1:0]  src_reg2_i,
  input  wire logic [REG_W-1:0]  src_reg3_i,
  output logic                   done_o,
  output logic                   conflict_o,
  output logic                   full_res_o,
  output logic [OCC_W-1:0]       occupancy_o,
  input  wire logic              cfg_we_i,
  input  wire logic [EXW_W-1:0]  cfg_wdata_i
);

  state_e            state_q, state_d;
  logic [EXW_W-1:0]  exec_width_q;
  logic              conflict_q, full_q;
  cmd_t              cmd;
  link_t             link [DEPTH+1];
  logic [DEPTH:0]    grant;
  logic [CMP_W-1:0]  cap;
  logic              full;
  logic              accept;

  assign accept = start && !busy;

  // Command broadcast with clamped source count
  always_comb begin
    cmd.en      = accept;
    cmd.op      = op_i;
    cmd.warp    = warp_id_i;
    cmd.dest    = dst_reg_i;
    cmd.latency = latency_i;
    cmd.nsrc    = (num_src_i > NSRC_W'(SRC_LIMIT)) ? NSRC_W'(SRC_LIMIT) : num_src_i;
    cmd.src[0]  = src_reg0_i;
    cmd.src[1]  = src_reg1_i;
    cmd.src[2]  = src_reg2_i;
    cmd.src[3]  = src_reg3_i;
  end

  // Capacity check against the live count before the item
  always_comb begin
    cap  = (CMP_W'(exec_width_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(exec_width_q);
    full = CMP_W'(link[DEPTH].count) >= cap;
  end

  // Chain heads
  assign link[0].hit   = 1'b0;
  assign link[0].count = '0;
  assign grant[0]      = (op_i == OP_ISSUE) && !full && (latency_i != '0);

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ebrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .grant_i (grant[i]),
      .grant_o (grant[i+1]),
      .link_i  (link[i]),
      .link_o  (link[i+1])
    );
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_width_q <= EXW_W'(DEPTH);
    end else if (cfg_we_i) begin
      exec_width_q <= cfg_wdata_i;
    end
  end

  // Flags captured at the accepting edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conflict_q <= 1'b0;
      full_q     <= 1'b0;
    end else if (accept) begin
      conflict_q <= (op_i == OP_CHECK) && link[DEPTH].hit;
      full_q     <= (op_i == OP_ISSUE) && full;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        busy    = 1'b1;
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result ports; the count reflects the updated row
  assign conflict_o  = conflict_q;
  assign full_res_o  = full_q;
  assign occupancy_o = OCC_W'(link[DEPTH].count);

endmodule : exec_buffer_register_scoreboard
`default_nettype wire

FILE: hw/rtl/ebrs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebrs_checker
// Port-level checks on the scoreboard's command and result timing.
// ----------------------------------------------------------------------------
module ebrs_checker
  import ebrs_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire logic              conflict_o,
  input wire logic              full_res_o,
  input wire logic [OCC_W-1:0]  occupancy_o
);

  // Every accepted item gets its result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("item accepted without a result on the next cycle");

  // A result strobe always drops again after it is raised
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result only arrives while the block reports busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result shown while not busy");

  // One item cannot both conflict and be refused
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(conflict_o && full_res_o))
    else $error("conflict and full reported together");

  // Occupancy stays within the table
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= OCC_W'(DEPTH)))
    else $error("occupancy beyond table depth");

endmodule : ebrs_checker

bind exec_buffer_register_scoreboard ebrs_checker u_ebrs_checker (.*);
`default_nettype wire
